[sv/sibm_pkg.sv]
// Package for the scanline IRQ bank mapper.
// Holds command and register codes, reset values, the mapper state view and
// the fixed-bank helper. It depends on nothing else.
`default_nettype none

package sibm_pkg;

   localparam int BANK_REG_COUNT = 8;
   localparam int BANK_IDX_W     = $clog2(BANK_REG_COUNT);

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 8;
   localparam int OFFSET_W  = 19;
   localparam int SIZE_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PRG_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHR_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SCANLINE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRG_SIZE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_SIZE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_MIRROR = 2'd2;

   // address bits 14:13 of a bus address at or above 0x8000
   localparam logic [1:0] REGION_BANK   = 2'd0;
   localparam logic [1:0] REGION_MIRROR = 2'd1;
   localparam logic [1:0] REGION_LATCH  = 2'd2;
   localparam logic [1:0] REGION_ENABLE = 2'd3;

   localparam logic [SIZE_W-1:0] RESET_PRG_SIZE = 6'd2;
   localparam logic [SIZE_W-1:0] RESET_PAT_SIZE = 6'd0;

   typedef logic [BANK_REG_COUNT-1:0][DATA_W-1:0] bank_regs_type;

   // bank registers after reset: 6 and 7 hold the last two program banks
   localparam logic [DATA_W-1:0] RESET_SECOND_LAST =
      {1'b0, RESET_PRG_SIZE, 1'b0} - DATA_W'(2);
   localparam bank_regs_type RESET_BANK_REGS =
      {RESET_SECOND_LAST | DATA_W'(1), RESET_SECOND_LAST,
       {((BANK_REG_COUNT-2)*DATA_W){1'b0}}};

   typedef struct packed {
      logic [DATA_W-1:0] bank_select;
      bank_regs_type     bank_regs;
      logic [SIZE_W-1:0] prg_size;
      logic [SIZE_W-1:0] pat_size;
   } sibm_view_type;

   typedef struct packed {
      logic mirror;
      logic irq_raise;
      logic irq_clear;
   } sibm_flags_type;

   // 2P-2 with P = 0 taken as 1; the last bank is this value with bit 0 set
   function automatic logic [DATA_W-1:0] sibm_second_last(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] p;
      p = (size == '0) ? SIZE_W'(1) : size;
      return {1'b0, p, 1'b0} - DATA_W'(2);
   endfunction

endpackage

`default_nettype wire

[sv/sibm_state.sv]
// Mapper state: size registers, bank select, bank registers, mirroring and
// the scanline IRQ counter. Applies one CPU write or tick per step.
// Depends on sibm_pkg.
`default_nettype none

module sibm_state
   import sibm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_write_data,
   input  wire logic                 step,
   input  wire logic [CMD_W-1:0]     command,
   input  wire logic [ADDR_W-1:0]    address,
   input  wire logic [DATA_W-1:0]    write_data,
   output sibm_view_type             view,
   output sibm_flags_type            flags
);

   logic [SIZE_W-1:0] prg_size_ff, prg_size_in;
   logic [SIZE_W-1:0] pat_size_ff, pat_size_in;
   logic              init_mirror_ff, init_mirror_in;
   logic [DATA_W-1:0] bank_select_ff, bank_select_in;
   bank_regs_type     bank_regs_ff, bank_regs_in;
   logic              mirroring_ff, mirroring_in;
   logic [DATA_W-1:0] irq_latch_ff, irq_latch_in;
   logic [DATA_W-1:0] irq_counter_ff, irq_counter_in;
   logic              irq_enabled_ff, irq_enabled_in;
   logic              reload_ff, reload_in;

   logic [DATA_W-1:0]     fixed_bank;
   logic [BANK_IDX_W-1:0] sel;
   logic [DATA_W-1:0]     bank_val;
   logic                  raise;
   logic                  clear;

   assign fixed_bank = sibm_second_last(csr_write_data);
   assign sel        = bank_select_ff[BANK_IDX_W-1:0];

   always_comb begin
      bank_val = write_data;
      if (sel <= BANK_IDX_W'(1)) begin
         bank_val = {write_data[DATA_W-1:1], 1'b0};
      end
      if (sel >= BANK_IDX_W'(6)) begin
         bank_val = {2'b00, write_data[5:0]};
      end
   end

   always_comb begin
      prg_size_in    = prg_size_ff;
      pat_size_in    = pat_size_ff;
      init_mirror_in = init_mirror_ff;
      bank_select_in = bank_select_ff;
      bank_regs_in   = bank_regs_ff;
      mirroring_in   = mirroring_ff;
      irq_latch_in   = irq_latch_ff;
      irq_counter_in = irq_counter_ff;
      irq_enabled_in = irq_enabled_ff;
      reload_in      = reload_ff;
      raise          = 1'b0;
      clear          = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_PRG_SIZE: begin
               prg_size_in     = csr_write_data;
               bank_regs_in[6] = fixed_bank;
               bank_regs_in[7] = {fixed_bank[DATA_W-1:1], 1'b1};
            end
            CSR_PAT_SIZE: begin
               pat_size_in = csr_write_data;
            end
            CSR_INITIAL_MIRROR: begin
               init_mirror_in = csr_write_data[0];
               mirroring_in   = csr_write_data[0];
            end
            default: begin
            end
         endcase
      end else if (step) begin
         case (command)
            CMD_CPU_WRITE: begin
               if (address[15]) begin
                  case (address[14:13])
                     REGION_BANK: begin
                        if (address[0]) begin
                           bank_regs_in[sel] = bank_val;
                        end else begin
                           bank_select_in = write_data;
                        end
                     end
                     REGION_MIRROR: begin
                        if (!address[0]) begin
                           mirroring_in = ~write_data[0];
                        end
                     end
                     REGION_LATCH: begin
                        if (address[0]) begin
                           reload_in = 1'b1;
                        end else begin
                           irq_latch_in = write_data;
                        end
                     end
                     REGION_ENABLE: begin
                        irq_enabled_in = address[0];
                        clear          = ~address[0];
                     end
                     default: begin
                     end
                  endcase
               end
            end
            CMD_SCANLINE: begin
               if (irq_counter_ff == '0 || reload_ff) begin
                  irq_counter_in = irq_latch_ff;
                  reload_in      = 1'b0;
               end else begin
                  irq_counter_in = irq_counter_ff - DATA_W'(1);
               end
               raise = (irq_counter_ff != '0) && (irq_counter_in == '0) && irq_enabled_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_size_ff     <= RESET_PRG_SIZE;
         pat_size_ff     <= RESET_PAT_SIZE;
         init_mirror_ff  <= 1'b0;
         bank_select_ff  <= '0;
         bank_regs_ff    <= RESET_BANK_REGS;
         mirroring_ff    <= 1'b0;
         irq_latch_ff    <= '0;
         irq_counter_ff  <= '0;
         irq_enabled_ff  <= 1'b0;
         reload_ff       <= 1'b0;
      end else begin
         prg_size_ff    <= prg_size_in;
         pat_size_ff    <= pat_size_in;
         init_mirror_ff <= init_mirror_in;
         bank_select_ff <= bank_select_in;
         bank_regs_ff   <= bank_regs_in;
         mirroring_ff   <= mirroring_in;
         irq_latch_ff   <= irq_latch_in;
         irq_counter_ff <= irq_counter_in;
         irq_enabled_ff <= irq_enabled_in;
         reload_ff      <= reload_in;
      end
   end

   assign view.bank_select = bank_select_ff;
   assign view.bank_regs   = bank_regs_ff;
   assign view.prg_size    = prg_size_ff;
   assign view.pat_size    = pat_size_ff;

   // mirroring reported is the value after this item
   assign flags.mirror    = mirroring_in;
   assign flags.irq_raise = raise;
   assign flags.irq_clear = clear;

endmodule

`default_nettype wire

[sv/sibm_xlate.sv]
// Address translation: program and pattern reads to a ROM byte offset,
// using the current bank registers and swap modes.
// Depends on sibm_pkg.
`default_nettype none

module sibm_xlate
   import sibm_pkg::*;
(
   input  wire logic [CMD_W-1:0]  command,
   input  wire logic [ADDR_W-1:0] address,
   input  wire sibm_view_type     view,
   output logic [OFFSET_W-1:0]    rom_offset,
   output logic                   unmapped
);

   logic [DATA_W-1:0] second_last;
   logic [DATA_W-1:0] prg_bank;
   logic [SIZE_W-1:0] prg_units;
   logic [19:0]       prg_mask;
   logic [20:0]       prg_raw;
   logic [OFFSET_W-1:0] prg_offset;

   logic [12:0]       chr_addr;
   logic [DATA_W-1:0] chr_bank;
   logic [17:0]       chr_raw;
   logic [18:0]       chr_mask;
   logic [OFFSET_W-1:0] chr_offset;

   assign second_last = sibm_second_last(view.prg_size);
   assign prg_units   = (view.prg_size == '0) ? SIZE_W'(1) : view.prg_size;

   always_comb begin
      case (address[14:13])
         2'd0:    prg_bank = view.bank_select[6] ? second_last : view.bank_regs[6];
         2'd1:    prg_bank = view.bank_regs[7];
         2'd2:    prg_bank = view.bank_select[6] ? view.bank_regs[6] : second_last;
         default: prg_bank = {second_last[DATA_W-1:1], 1'b1};
      endcase
   end

   assign prg_raw    = {prg_bank, address[12:0]};
   assign prg_mask   = {prg_units, 14'd0} - 20'd1;
   assign prg_offset = prg_raw[OFFSET_W-1:0] & prg_mask[OFFSET_W-1:0];

   assign chr_addr = {address[12] ^ view.bank_select[7], address[11:0]};

   always_comb begin
      if (!chr_addr[12]) begin
         chr_bank = view.bank_regs[{2'b00, chr_addr[11]}];
         chr_raw  = {chr_bank[DATA_W-1:1], chr_addr[10:0]};
      end else begin
         chr_bank = view.bank_regs[{1'b0, chr_addr[11:10]} + BANK_IDX_W'(2)];
         chr_raw  = {chr_bank, chr_addr[9:0]};
      end
   end

   assign chr_mask   = {view.pat_size, 13'd0} - 19'd1;
   assign chr_offset = (view.pat_size == '0) ? {6'd0, address[12:0]}
                                             : ({1'b0, chr_raw} & chr_mask);

   always_comb begin
      rom_offset = '0;
      unmapped   = 1'b0;
      case (command)
         CMD_PRG_READ: begin
            if (!address[15]) begin
               unmapped = 1'b1;
            end else begin
               rom_offset = prg_offset;
            end
         end
         CMD_CHR_READ: begin
            rom_offset = chr_offset;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/scanline_irq_bank_mapper_top.sv]
// Scanline IRQ bank mapper, top level.
// Throughput: one item per cycle unless a result waits on rsp_ready; each
// item is applied in the cycle it moves from the input register to the
// result register.
// Reset (synchronous): sizes 2 and 0, mirroring horizontal, counter and
// flags cleared, bank registers 6 and 7 at 2 and 3, both channels empty.
`default_nettype none

module scanline_irq_bank_mapper_top
   import sibm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [ADDR_W-1:0]    req_address,
   input  wire logic [DATA_W-1:0]    req_write_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [OFFSET_W-1:0]       rsp_rom_offset,
   output logic                      rsp_unmapped,
   output logic                      rsp_mirror_mode,
   output logic                      rsp_irq_raise,
   output logic                      rsp_irq_clear,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_write_data
);

   logic                in_valid_ff;
   logic [CMD_W-1:0]    command_ff;
   logic [ADDR_W-1:0]   address_ff;
   logic [DATA_W-1:0]   write_data_ff;

   logic                out_valid_ff;
   logic [OFFSET_W-1:0] rom_offset_ff;
   logic                unmapped_ff;
   logic                mirror_ff;
   logic                raise_ff;
   logic                clear_ff;

   logic                step;
   sibm_view_type       view;
   sibm_flags_type      flags;
   logic [OFFSET_W-1:0] rom_offset;
   logic                unmapped;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   // no csr write while a word waits to be applied
   assign csr_ready = !in_valid_ff;

   sibm_state u_state (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .step           (step),
      .command        (command_ff),
      .address        (address_ff),
      .write_data     (write_data_ff),
      .view           (view),
      .flags          (flags)
   );

   sibm_xlate u_xlate (
      .command    (command_ff),
      .address    (address_ff),
      .view       (view),
      .rom_offset (rom_offset),
      .unmapped   (unmapped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         command_ff    <= req_command;
         address_ff    <= req_address;
         write_data_ff <= req_write_data;
      end
      if (step) begin
         rom_offset_ff <= rom_offset;
         unmapped_ff   <= unmapped;
         mirror_ff     <= flags.mirror;
         raise_ff      <= flags.irq_raise;
         clear_ff      <= flags.irq_clear;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rom_offset  = rom_offset_ff;
   assign rsp_unmapped    = unmapped_ff;
   assign rsp_mirror_mode = mirror_ff;
   assign rsp_irq_raise   = raise_ff;
   assign rsp_irq_clear   = clear_ff;

endmodule

`default_nettype wire
